### hdl/alarm_severity_table_with_history_top_macros.svh
// ----------------------------------------------------------------------------
// Alarm severity table with history - assertion macros
// Concurrent assertion shorthands for the alarm table top level.
// ----------------------------------------------------------------------------
`ifndef ALARM_SEVERITY_TABLE_WITH_HISTORY_TOP_MACROS_SVH
`define ALARM_SEVERITY_TABLE_WITH_HISTORY_TOP_MACROS_SVH

// same-cycle implication
`define ASHT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/asht_pkg.sv
// ----------------------------------------------------------------------------
// Alarm severity table package
// Shared types and constants for the alarm table with event history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asht_pkg;

  localparam int DEF_NUM_ALARM_TYPES = 8;
  localparam int DEF_HISTORY_DEPTH   = 64;
  localparam int MAX_HIST_OUT        = 64;
  localparam int COUNT_MAX           = 15;

  localparam logic [1:0] LEVEL_OK   = 2'd0;
  localparam logic [1:0] LEVEL_CRIT = 2'd2;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_HIST  = 2'd2
  } req_e;

  typedef struct packed {
    logic       act;
    logic [1:0] lvl;
  } alarm_ent_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  lvl;
    logic [31:0] stamp;
  } hist_rec_t;

endpackage

### hdl/alarm_severity_table_with_history_top.sv
// ----------------------------------------------------------------------------
// Alarm severity table with history - top level
// Per-alarm active/severity table, event ring and summary of active alarms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request per transaction:
//   set, clear or history read. Output channel (out_valid_o/out_ready_i)
//   carries result transactions; last_o marks the final one of a request.
//   A set or clear with an alarm index in range reads the alarm entry, writes
//   it back if it changes, then rescans the alarm table memory one entry per
//   cycle; its result is loaded into the output register from S_RESP after
//   S_SCAN_END. Other single results go from S_IDLE straight to S_RESP to be
//   loaded. A history read streams records newest first, each one a ring
//   memory read (S_HRD), then an output load (S_HOUT). The block works
//   on one request at a time; in_ready_o rises again once the final result
//   sits in the output register, so the next request overlaps its delivery.
//   Reset clears the alarm table through per-entry valid bits, the ring
//   pointer and fill count and the summary; no clearing pass is needed.
//   When the receiver stalls, the output register holds and the block
//   waits before loading the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "alarm_severity_table_with_history_top_macros.svh"

module alarm_severity_table_with_history_top
  import asht_pkg::*;
#(
  parameter int NUM_ALARM_TYPES = DEF_NUM_ALARM_TYPES,
  parameter int HISTORY_DEPTH   = DEF_HISTORY_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [2:0]  alarm_kind_i,
  input  logic [1:0]  level_i,
  input  logic [31:0] now_ms_i,
  input  logic [6:0]  read_limit_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  overall_level_o,
  output logic [3:0]  active_count_o,
  output logic        logged_o,
  output logic        hist_valid_o,
  output logic [2:0]  hist_kind_o,
  output logic [1:0]  hist_level_o,
  output logic [31:0] hist_time_o,
  output logic        last_o
);

  localparam int KW       = $clog2(NUM_ALARM_TYPES);
  localparam int CW       = $clog2(NUM_ALARM_TYPES + 1);
  localparam int HW       = $clog2(HISTORY_DEPTH);
  localparam int FW       = $clog2(HISTORY_DEPTH + 1);
  localparam int MaxCount = (NUM_ALARM_TYPES > COUNT_MAX) ? COUNT_MAX : NUM_ALARM_TYPES;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_LOOK     = 8'b0000_0010,
    S_UPD      = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_SCAN_END = 8'b0001_0000,
    S_RESP     = 8'b0010_0000,
    S_HRD      = 8'b0100_0000,
    S_HOUT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // request payload
  logic [1:0]  req_q;
  logic [2:0]  kind_q;
  logic [1:0]  lvl_q;
  logic [31:0] now_q;
  logic [KW-1:0] kind_idx;

  // alarm table memory
  alarm_ent_t                 tab_mem [NUM_ALARM_TYPES];
  logic [NUM_ALARM_TYPES-1:0] tab_vld_q, tab_vld_d;
  alarm_ent_t                 tab_rdata_q, tab_wdata, ent;
  logic                       tab_rvld_q, tab_re, tab_we;
  logic [KW-1:0]              tab_raddr;

  // history ring memory
  hist_rec_t     ring_mem [HISTORY_DEPTH];
  hist_rec_t     ring_rdata_q, ring_wdata;
  logic          ring_re, ring_we;
  logic [HW-1:0] head_q, head_d, rptr_q, rptr_d, head_prev;
  logic [FW-1:0] fill_q, fill_d;

  // scan and summary
  logic [KW-1:0] scan_idx_q, scan_idx_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] acc_cnt_q, acc_cnt_d, acc_cnt_n;
  logic [1:0]    acc_top_q, acc_top_d, acc_top_n;
  logic [1:0]    overall_q, overall_d;
  logic [3:0]    count_q, count_d;
  logic          logged_q, logged_d;
  logic [6:0]    remain_q, remain_d, hcnt;

  // output register
  logic        out_valid_q, out_valid_d, out_load;
  logic        logged_n, hvalid_n, last_n;
  hist_rec_t   hrec_n;
  logic        logged_oq, hvalid_oq, last_oq;
  hist_rec_t   hrec_oq;
  logic [1:0]  overall_oq;
  logic [3:0]  count_oq;

  logic in_acc;
  logic [1:0] lvl_sat;
  logic in_range;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign lvl_sat    = (level_i > LEVEL_CRIT) ? LEVEL_CRIT : level_i;
  assign in_range   = (int'(alarm_kind_i) < NUM_ALARM_TYPES);
  assign kind_idx   = KW'(kind_q);
  assign head_prev  = (head_q == '0) ? HW'(HISTORY_DEPTH - 1) : head_q - 1'b1;
  assign ent        = tab_rvld_q ? tab_rdata_q : alarm_ent_t'('0);
  assign acc_top_n  = (pend_q && ent.act && ent.lvl > acc_top_q) ? ent.lvl : acc_top_q;
  assign acc_cnt_n  = acc_cnt_q + CW'(pend_q && ent.act);

  always_comb begin : p_hcnt
    int m;
    m = int'(fill_q);
    if (m > int'(read_limit_i)) m = int'(read_limit_i);
    if (m > MAX_HIST_OUT) m = MAX_HIST_OUT;
    hcnt = 7'(m);
  end

  always_comb begin
    state_d     = state_q;
    tab_vld_d   = tab_vld_q;
    head_d      = head_q;
    fill_d      = fill_q;
    rptr_d      = rptr_q;
    scan_idx_d  = scan_idx_q;
    pend_d      = 1'b0;
    acc_cnt_d   = acc_cnt_q;
    acc_top_d   = acc_top_q;
    overall_d   = overall_q;
    count_d     = count_q;
    logged_d    = logged_q;
    remain_d    = remain_q;
    tab_re      = 1'b0;
    tab_raddr   = kind_idx;
    tab_we      = 1'b0;
    tab_wdata   = '0;
    ring_re     = 1'b0;
    ring_we     = 1'b0;
    ring_wdata  = '{kind: kind_q, lvl: lvl_q, stamp: now_q};
    out_load    = 1'b0;
    logged_n    = 1'b0;
    hvalid_n    = 1'b0;
    last_n      = 1'b1;
    hrec_n      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          logged_d = 1'b0;
          case (req_e'(req_type_i))
            REQ_SET, REQ_CLEAR: begin
              state_d = in_range ? S_LOOK : S_RESP;
            end
            REQ_HIST: begin
              remain_d = hcnt;
              rptr_d   = head_prev;
              state_d  = (hcnt == '0) ? S_RESP : S_HRD;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_LOOK: begin
        tab_re  = 1'b1;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (req_e'(req_q) == REQ_SET) begin
          if (!ent.act || ent.lvl != lvl_q) begin
            tab_we    = 1'b1;
            tab_wdata = '{act: 1'b1, lvl: lvl_q};
            ring_we   = 1'b1;
            head_d    = (head_q == HW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
            if (fill_q != FW'(HISTORY_DEPTH)) fill_d = fill_q + 1'b1;
            logged_d  = 1'b1;
          end
        end else if (ent.act) begin
          tab_we    = 1'b1;
          tab_wdata = '{act: 1'b0, lvl: LEVEL_OK};
        end
        if (tab_we) tab_vld_d[kind_idx] = 1'b1;
        scan_idx_d = '0;
        acc_cnt_d  = '0;
        acc_top_d  = LEVEL_OK;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        tab_re    = 1'b1;
        tab_raddr = scan_idx_q;
        pend_d    = 1'b1;
        acc_cnt_d = acc_cnt_n;
        acc_top_d = acc_top_n;
        if (scan_idx_q == KW'(NUM_ALARM_TYPES - 1)) begin
          state_d = S_SCAN_END;
        end else begin
          scan_idx_d = scan_idx_q + 1'b1;
        end
      end
      S_SCAN_END: begin
        overall_d = acc_top_n;
        count_d   = (int'(acc_cnt_n) > COUNT_MAX) ? 4'(COUNT_MAX) : 4'(acc_cnt_n);
        state_d   = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          logged_n = logged_q;
          state_d  = S_IDLE;
        end
      end
      S_HRD: begin
        ring_re = 1'b1;
        state_d = S_HOUT;
      end
      S_HOUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          hvalid_n = 1'b1;
          hrec_n   = ring_rdata_q;
          last_n   = (remain_q == 7'd1);
          remain_d = remain_q - 7'd1;
          rptr_d   = (rptr_q == '0) ? HW'(HISTORY_DEPTH - 1) : rptr_q - 1'b1;
          state_d  = last_n ? S_IDLE : S_HRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tab_vld_q   <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      acc_cnt_q   <= '0;
      acc_top_q   <= LEVEL_OK;
      overall_q   <= LEVEL_OK;
      count_q     <= '0;
      logged_q    <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tab_vld_q   <= tab_vld_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      scan_idx_q  <= scan_idx_d;
      pend_q      <= pend_d;
      acc_cnt_q   <= acc_cnt_d;
      acc_top_q   <= acc_top_d;
      overall_q   <= overall_d;
      count_q     <= count_d;
      logged_q    <= logged_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rptr_q <= rptr_d;
    if (in_acc) begin
      req_q  <= req_type_i;
      kind_q <= alarm_kind_i;
      lvl_q  <= lvl_sat;
      now_q  <= now_ms_i;
    end
    if (out_load) begin
      overall_oq <= overall_q;
      count_oq   <= count_q;
      logged_oq  <= logged_n;
      hvalid_oq  <= hvalid_n;
      hrec_oq    <= hrec_n;
      last_oq    <= last_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      tab_mem[kind_idx] <= tab_wdata;
    end
    if (tab_re) begin
      tab_rdata_q <= tab_mem[tab_raddr];
      tab_rvld_q  <= tab_vld_q[tab_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[head_q] <= ring_wdata;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[rptr_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign overall_level_o = overall_oq;
  assign active_count_o  = count_oq;
  assign logged_o        = logged_oq;
  assign hist_valid_o    = hvalid_oq;
  assign hist_kind_o     = hrec_oq.kind;
  assign hist_level_o    = hrec_oq.lvl;
  assign hist_time_o     = hrec_oq.stamp;
  assign last_o          = last_oq;

  `ASHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "request accepted but block still ready")
  `ASHT_ASSERT_NEXT(a_hist_step, clk_i, rst_ni, state_q == S_HOUT && out_load, remain_q == $past(remain_q) - 7'd1, "history count did not advance")
  `ASHT_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, out_valid_o, int'(active_count_o) <= MaxCount, "active count above alarm count")

endmodule
